/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
		else $error("assertion failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, cond, cons)
`define ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

/* rtl/s256_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package s256_pkg;

	localparam int unsigned Rounds = 64;
	localparam int unsigned RoundW = $clog2(Rounds);
	localparam int unsigned HashWords = 8;
	localparam int unsigned IndexW = $clog2(HashWords);

	typedef logic [31:0] word_t;
	typedef logic [RoundW-1:0] round_t;
	typedef logic [IndexW-1:0] index_t;
	// Element 0 is the least significant word (variable a of the working set).
	typedef logic [HashWords-1:0][31:0] hash_t;

	localparam round_t FirstRound = '0;
	localparam round_t LastRound = RoundW'(Rounds - 1);
	localparam index_t LastWord = IndexW'(HashWords - 1);

	localparam hash_t InitHash = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t RoundK [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Status of the digest output buffer.
	typedef struct packed {
		logic busy;
	} dig_status_t;

endpackage

`default_nettype wire

/* rtl/s256_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface s256_in_if
	import s256_pkg::*;
;
	logic valid;
	logic ready;
	word_t schedule_word;
	logic new_message;
	logic final_block;

	modport source (output valid, output schedule_word, output new_message,
		output final_block, input ready);
	modport sink (input valid, input schedule_word, input new_message,
		input final_block, output ready);
endinterface

`default_nettype wire

/* rtl/s256_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface s256_out_if
	import s256_pkg::*;
;
	logic valid;
	logic ready;
	word_t digest_word;
	index_t word_index;
	logic last;

	modport source (output valid, output digest_word, output word_index,
		output last, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last, output ready);
endinterface

`default_nettype wire

/* rtl/s256_round.sv */
`timescale 1ns / 1ps
`default_nettype none

// One SHA-256 compression round on the working variables a..h.
module s256_round
	import s256_pkg::*;
(
	input  hash_t vars,
	input  word_t k,
	input  word_t w,
	output hash_t vars_next
);

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	word_t sum1;
	word_t sum0;
	word_t ch;
	word_t maj;
	word_t t1;
	word_t t2;

	always_comb begin
		sum1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
		sum0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
		ch = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
		maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
		t1 = vars[7] + sum1 + ch + k + w;
		t2 = sum0 + maj;

		vars_next[7] = vars[6];
		vars_next[6] = vars[5];
		vars_next[5] = vars[4];
		vars_next[4] = vars[3] + t1;
		vars_next[3] = vars[2];
		vars_next[2] = vars[1];
		vars_next[1] = vars[0];
		vars_next[0] = t1 + t2;
	end

endmodule

`default_nettype wire

/* rtl/s256_digest_out.sv */
`timescale 1ns / 1ps
`default_nettype none

// Holds a snapshot of the digest and shifts it out one word per handshake.
module s256_digest_out
	import s256_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  hash_t        hash,
	output dig_status_t  status,
	s256_out_if.source   digest
);

	`include "assert_macros.svh"

	hash_t words_q;
	index_t idx_q;
	logic busy_q;
	logic pop;

	assign pop = digest.valid && digest.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			busy_q <= 1'b0;
		end else if (load) begin
			idx_q <= '0;
			busy_q <= 1'b1;
		end else if (pop) begin
			idx_q <= idx_q + index_t'(1);
			if (idx_q == LastWord) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= hash;
		end else if (pop) begin
			words_q <= {32'h0, words_q[HashWords-1:1]};
		end
	end

	assign digest.valid = busy_q;
	assign digest.digest_word = words_q[0];
	assign digest.word_index = idx_q;
	assign digest.last = (idx_q == LastWord);

	assign status.busy = busy_q;

	// A new snapshot never lands on top of words still waiting.
	`ASSERT_SAME(a_no_overwrite, clk, arst_n, load, !busy_q)
	// After a load the first word offered is word zero.
	`ASSERT_NEXT(a_load_starts, clk, arst_n, load, busy_q && idx_q == '0)
	// Taking the last word empties the buffer.
	`ASSERT_NEXT(a_last_ends, clk, arst_n, pop && digest.last && !load, !busy_q)

endmodule

`default_nettype wire

/* rtl/sha256_compression_rounds.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Payload                                  | Word
// sched    | in  | schedule_word, new_message, final_block  | one round of one block
// digest   | out | digest_word, word_index, last            | one word of the final hash
//
// Each accepted sched word performs one full compression round in the cycle it is
// accepted, so the block sustains one word per clock outside the stall below; the
// round adder chain sets that. After the word of round 63 of a final block, eight
// digest words follow, one per cycle while the sink takes them; the first is offered
// in the cycle after that round. Reset restores the initial hash values and round zero.
// The digest buffer decouples the two sides: sched only stalls when the word of round 63
// arrives while the previous digest has not yet been fully taken.
module sha256_compression_rounds
	import s256_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	s256_in_if.sink  sched,
	s256_out_if.source digest
);

	`include "assert_macros.svh"

	round_t round_q;
	hash_t work_q;
	hash_t chain_q;

	hash_t chain_base;
	hash_t round_in;
	hash_t round_out;
	hash_t chain_sum;

	dig_status_t dig_status;

	logic accept;
	logic first_round;
	logic last_round;
	logic dig_load;

	assign first_round = (round_q == FirstRound);
	assign last_round = (round_q == LastRound);

	// The only stall: a block would finish while the previous digest still waits.
	assign sched.ready = !(dig_status.busy && last_round);
	assign accept = sched.valid && sched.ready;

	// A new message starts from the initial values; round zero loads a..h from the chain.
	always_comb begin
		chain_base = (first_round && sched.new_message) ? InitHash : chain_q;
		round_in = first_round ? chain_base : work_q;
	end

	s256_round u_round (
		.vars      (round_in),
		.k         (RoundK[round_q]),
		.w         (sched.schedule_word),
		.vars_next (round_out)
	);

	// Feed-forward of the working variables into the chaining value.
	always_comb begin
		for (int i = 0; i < HashWords; i++) begin
			chain_sum[i] = chain_q[i] + round_out[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= FirstRound;
			chain_q <= InitHash;
		end else if (accept) begin
			round_q <= round_q + round_t'(1);
			if (last_round) begin
				chain_q <= chain_sum;
			end else if (first_round) begin
				chain_q <= chain_base;
			end
		end
	end

	// The working variables are always reloaded at round zero before they are used.
	always_ff @(posedge clk) begin
		if (accept) begin
			work_q <= round_out;
		end
	end

	assign dig_load = accept && last_round && sched.final_block;

	s256_digest_out u_digest (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (dig_load),
		.hash   (chain_sum),
		.status (dig_status),
		.digest (digest)
	);

	// The round counter wraps back to zero after the last round.
	`ASSERT_NEXT(a_round_wrap, clk, arst_n, accept && last_round, round_q == FirstRound)
	// A final block shows its first digest word right after its last round.
	`ASSERT_NEXT(a_digest_follows, clk, arst_n, dig_load,
		digest.valid && digest.word_index == '0 && digest.digest_word == $past(chain_sum[0]))
	// Input only stalls at the last round with a digest pending.
	`ASSERT_SAME(a_stall_reason, clk, arst_n, !sched.ready, dig_status.busy && last_round)

endmodule

`default_nettype wire

/* test/sha256_compression_rounds_tb.sv */
`timescale 1ns / 1ps

module sha256_compression_rounds_tb;
	import s256_pkg::*;

	// The run ends with a failure once this many clock cycles have gone by.
	localparam int unsigned CycleLimit = 200000;

	// Cycles to watch the digest port after the last expected word.
	// This catches stray extra words.
	localparam int unsigned TailCycles = 24;

	// The standard SHA-256 round constants and initial hash. These are kept here
	// on purpose, so that a wrong table inside the block shows up as a mismatch.
	localparam word_t RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t StartHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Flow-control modes that the run steps through.
	typedef enum {
		FlowSteady,      // no idling on either side
		FlowSenderIdle,  // the schedule source idles most cycles
		FlowSinkStall,   // the digest sink stalls most cycles
		FlowBothIdle     // both sides idle about a third of the time
	} flow_mode_t;

	// One schedule word as queued for the driver.
	typedef struct {
		word_t schedule_word;
		logic new_message;
		logic final_block;
	} sched_item_t;

	// One digest word that the block owes us.
	typedef struct {
		word_t digest_word;
		index_t word_index;
		logic last;
	} digest_entry_t;

	logic clk;
	logic arst_n;

	s256_in_if sched_ch ();
	s256_out_if digest_ch ();

	sha256_compression_rounds dut (
		.clk(clk),
		.arst_n(arst_n),
		.sched(sched_ch),
		.digest(digest_ch)
	);

	// Words waiting to be offered, and digest words the hash model has
	// produced but the block has not yet delivered.
	sched_item_t sched_backlog [$];
	digest_entry_t digest_due [$];

	flow_mode_t flow_mode = FlowSteady;

	// This tracks the round of the next queued word, so that the stimulus
	// can put the message flags on the rounds where they matter.
	int unsigned queued_round = 0;
	int unsigned queued_finals = 0;

	// This is the hash model: chaining value, working variables a..h and
	// the hidden round counter. It advances only on accepted schedule words.
	word_t chain_h [8];
	word_t work_v [8];
	round_t model_round;

	// These are tallies for the summary and the verdict.
	int unsigned rounds_taken = 0;
	int unsigned blocks_done = 0;
	int unsigned restarts_seen = 0;
	int unsigned digests_seen = 0;
	int unsigned words_checked = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// The monitor sets this when the driver's word was taken at the last
	// rising edge, so that the driver knows it may move on.
	logic sched_fire;

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// This is the percentage of cycles in which a side holds back in the
	// current mode.
	function automatic int unsigned stall_percent(bit sender_side);
		case (flow_mode)
			FlowSenderIdle: begin
				return sender_side ? 82 : 0;
			end
			FlowSinkStall: begin
				return sender_side ? 0 : 82;
			end
			FlowBothIdle: begin
				return 34;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	// This runs one compression round on an accepted word.
	// If the word closes a final block, it queues the eight digest words.
	task automatic compress_round(word_t w, logic new_msg, logic fin);
		word_t t1;
		word_t t2;
		word_t s1;
		word_t s0;
		word_t ch;
		word_t maj;
		if (model_round == '0) begin
			// A new message restarts the chain. Off round zero the flag means nothing.
			if (new_msg) begin
				chain_h = StartHash;
				restarts_seen++;
			end
			work_v = chain_h;
		end

		s1 = rotr(work_v[4], 6) ^ rotr(work_v[4], 11) ^ rotr(work_v[4], 25);
		ch = (work_v[4] & work_v[5]) ^ (~work_v[4] & work_v[6]);
		s0 = rotr(work_v[0], 2) ^ rotr(work_v[0], 13) ^ rotr(work_v[0], 22);
		maj = (work_v[0] & work_v[1]) ^ (work_v[0] & work_v[2]) ^ (work_v[1] & work_v[2]);
		t1 = work_v[7] + s1 + ch + RoundConst[model_round] + w;
		t2 = s0 + maj;

		work_v[7] = work_v[6];
		work_v[6] = work_v[5];
		work_v[5] = work_v[4];
		work_v[4] = work_v[3] + t1;
		work_v[3] = work_v[2];
		work_v[2] = work_v[1];
		work_v[1] = work_v[0];
		work_v[0] = t1 + t2;

		if (model_round == LastRound) begin
			for (int i = 0; i < 8; i++) begin
				chain_h[i] = chain_h[i] + work_v[i];
			end
			blocks_done++;
			// Only a final block releases the digest. Earlier rounds never do.
			if (fin) begin
				digests_seen++;
				for (int i = 0; i < 8; i++) begin
					digest_due.push_back('{
						digest_word: chain_h[i],
						word_index: index_t'(i),
						last: (i == 7)
					});
				end
			end
		end

		model_round = model_round + round_t'(1);
		rounds_taken++;
	endtask

	// This queues one schedule word and keeps track of its round.
	task automatic queue_word(word_t w, logic new_msg, logic fin);
		sched_backlog.push_back('{schedule_word: w, new_message: new_msg, final_block: fin});
		if (queued_round == 63 && fin) begin
			queued_finals++;
		end
		queued_round = (queued_round + 1) % 64;
	endtask

	// This queues a random word. The new-message flag is a coin toss at round
	// zero and the final flag is likely at round 63. Elsewhere both flags show
	// up now and then as noise that the block must ignore.
	task automatic queue_random_word();
		word_t w;
		logic new_msg;
		logic fin;
		w = $urandom;
		case ($urandom_range(0, 15))
			0: begin
				w = '0;
			end
			1: begin
				w = '1;
			end
			default: begin
			end
		endcase
		new_msg = (queued_round == 0) ? ($urandom_range(0, 1) == 1)
			: ($urandom_range(0, 9) == 0);
		fin = (queued_round == 63) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0);
		queue_word(w, new_msg, fin);
	endtask

	// This checks one delivered digest word against the oldest one owed.
	task automatic check_digest_word();
		digest_entry_t exp_w;
		if (digest_due.size() == 0) begin
			$error("digest word %h (index %0d) arrived with none expected",
				digest_ch.digest_word, digest_ch.word_index);
			error_count++;
		end else begin
			exp_w = digest_due.pop_front();
			words_checked++;
			if (digest_ch.digest_word !== exp_w.digest_word) begin
				$error("digest_word: expected %h, got %h", exp_w.digest_word,
					digest_ch.digest_word);
				error_count++;
			end
			if (digest_ch.word_index !== exp_w.word_index) begin
				$error("word_index: expected %0d, got %0d", exp_w.word_index,
					digest_ch.word_index);
				error_count++;
			end
			if (digest_ch.last !== exp_w.last) begin
				$error("last: expected %b, got %b", exp_w.last, digest_ch.last);
				error_count++;
			end
		end
	endtask

	// This waits until every queued word has been taken and every owed digest
	// word has arrived. It looks at falling edges, where the rising-edge
	// updates have settled.
	task automatic wait_for_drain();
		do begin
			@(negedge clk);
		end while (sched_backlog.size() != 0 || sched_ch.valid || digest_due.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#1 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Timed out after %0d cycles with %0d digest words outstanding",
				cycle_count, digest_due.size());
			$display("sha256_compression_rounds_tb: FAIL");
			$finish;
		end
	end

	// Monitor: this samples both handshakes at the rising edge. An accepted
	// schedule word is run through the hash model before the digest port is
	// checked, so a block with no delay on its output would not be flagged
	// falsely.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_fire <= 1'b0;
			chain_h = StartHash;
			work_v = '{default: '0};
			model_round = '0;
		end else begin
			sched_fire <= sched_ch.valid && sched_ch.ready;
			if (sched_ch.valid && sched_ch.ready) begin
				compress_round(sched_ch.schedule_word, sched_ch.new_message,
					sched_ch.final_block);
			end
			if (digest_ch.valid && digest_ch.ready) begin
				check_digest_word();
			end
		end
	end

	// Driver: this works on falling edges. A word stays on the bus until the
	// monitor reports that it was taken. After that the next word goes out,
	// or the bus idles, as the current mode decides.
	always @(negedge clk or negedge arst_n) begin : drive_sched
		sched_item_t nxt;
		if (!arst_n) begin
			sched_ch.valid <= 1'b0;
			sched_ch.schedule_word <= '0;
			sched_ch.new_message <= 1'b0;
			sched_ch.final_block <= 1'b0;
		end else if (!sched_ch.valid || sched_fire) begin
			if (sched_backlog.size() != 0
					&& $urandom_range(0, 99) >= stall_percent(1'b1)) begin
				nxt = sched_backlog.pop_front();
				sched_ch.valid <= 1'b1;
				sched_ch.schedule_word <= nxt.schedule_word;
				sched_ch.new_message <= nxt.new_message;
				sched_ch.final_block <= nxt.final_block;
			end else begin
				sched_ch.valid <= 1'b0;
			end
		end
	end

	// Digest sink: this drops ready at random, at the rate the mode asks for.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_ch.ready <= 1'b0;
		end else begin
			digest_ch.ready <= ($urandom_range(0, 99) >= stall_percent(1'b0));
		end
	end

	initial begin
		int unsigned mode_words;
		int unsigned mode_finals;
		flow_mode_t modes [4];
		modes = '{FlowSteady, FlowSenderIdle, FlowSinkStall, FlowBothIdle};

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The directed opening covers the first 25 rounds of the first block.
		// It starts a new message at round zero and drives word extremes. It
		// also sets stray new-message and final flags off their rounds, which
		// the block must ignore.
		queue_word(32'h0000_0000, 1'b1, 1'b0);
		queue_word(32'hffff_ffff, 1'b1, 1'b0);
		queue_word(32'h0000_0001, 1'b0, 1'b1);
		queue_word(32'h8000_0000, 1'b1, 1'b1);
		queue_word(32'h7fff_ffff, 1'b0, 1'b0);
		queue_word(32'hffff_fffe, 1'b0, 1'b0);
		for (int i = 6; i < 25; i++) begin
			queue_word((i % 2) ? 32'haaaa_aaaa : 32'h5555_5555, i == 10, i == 12);
		end

		// Then each flow mode in turn gets random blocks. A mode runs for at
		// least 60 words and until a final block has gone through, so every
		// mode sees a digest drained under its own stall pattern. Modes change
		// only once the previous one has fully drained.
		foreach (modes[m]) begin
			if (m != 0) begin
				wait_for_drain();
				@(posedge clk);
				flow_mode = modes[m];
			end
			mode_words = 0;
			mode_finals = queued_finals;
			while (mode_words < 60 || queued_finals == mode_finals) begin
				queue_random_word();
				mode_words++;
			end
		end

		wait_for_drain();
		repeat (TailCycles) @(posedge clk);

		$display("Ran %0d rounds over %0d whole blocks with %0d chain restarts,",
			rounds_taken, blocks_done, restarts_seen);
		$display("checked %0d digest words from %0d final blocks across 4 flow modes.",
			words_checked, digests_seen);
		if (error_count == 0) begin
			$display("sha256_compression_rounds_tb: PASS");
		end else begin
			$display("sha256_compression_rounds_tb: FAIL");
		end
		$finish;
	end

endmodule

/* sha256_compression_rounds.f */
+incdir+rtl
rtl/s256_pkg.sv
rtl/s256_in_if.sv
rtl/s256_out_if.sv
rtl/s256_round.sv
rtl/s256_digest_out.sv
rtl/sha256_compression_rounds.sv
test/sha256_compression_rounds_tb.sv
